### sv/pics_pkg.sv
// shared command, status and axis types of the polyline iso crossing sampler
`default_nettype none
package pics_pkg;

	// number of position axes and the index of the last one
	localparam int NAXES = 3;
	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_FIRST = 2'd0;
	localparam axis_t AXIS_LAST  = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic  load;       // capture the accepted item, shift the previous vertex
		logic  eval;       // classify the segment, load the divider operands
		logic  pick_cur;   // sampled point is the current vertex
		logic  div_step;   // one quotient bit
		logic  div_first;  // integer quotient bit, no remainder doubling
		logic  diff;       // per axis distance magnitudes
		logic  mul;        // scale one axis distance by the fraction
		logic  add;        // offset one axis from the previous vertex
		logic  commit;     // widen the box and load the result registers
		axis_t axis;
	} pics_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic emit_direct;  // current vertex is the sample
		logic emit_interp;  // sample value is crossed inside the segment
	} pics_stat_t;

endpackage
`default_nettype wire

### sv/polyline_iso_crossing_sampler.sv
// Polyline iso crossing sampler: one item at a time, fraction by a bit-serial divider.
// An item is taken in the idle state and classified in the next cycle; with no sample it is done there.
// A direct hit goes from classification straight to the commit; a crossing runs the one-bit-per-cycle divider,
// then the per axis distances and the shared axis multiplier for each axis in turn before the commit.
// A new item is taken while a finished result waits on the output register.
// Reset clears the register, the previous vertex and the box (marked empty) at once.
`default_nettype none
module polyline_iso_crossing_sampler #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                sample_value_we,
	input  wire signed [31:0]  sample_value,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire signed [31:0]  vertex_x,
	input  wire signed [31:0]  vertex_y,
	input  wire signed [31:0]  vertex_z,
	input  wire signed [31:0]  vertex_param,
	input  wire                fiber_start,
	input  wire                set_start,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic signed [31:0] box_min_x,
	output logic signed [31:0] box_min_y,
	output logic signed [31:0] box_min_z,
	output logic signed [31:0] box_max_x,
	output logic signed [31:0] box_max_y,
	output logic signed [31:0] box_max_z
);

	pics_pkg::pics_cmd_t  cmd;
	pics_pkg::pics_stat_t stat;

	// sequencing
	pics_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// arithmetic and state
	pics_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.sample_value_we (sample_value_we),
		.sample_value    (sample_value),
		.vertex_x        (vertex_x),
		.vertex_y        (vertex_y),
		.vertex_z        (vertex_z),
		.vertex_param    (vertex_param),
		.fiber_start     (fiber_start),
		.set_start       (set_start),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.box_min_x       (box_min_x),
		.box_min_y       (box_min_y),
		.box_min_z       (box_min_z),
		.box_max_x       (box_max_x),
		.box_max_y       (box_max_y),
		.box_max_z       (box_max_z)
	);

endmodule
`default_nettype wire

### sv/pics_dp.sv
// datapath: vertex history, crossing test, fraction divider, interpolation and bounding box
`default_nettype none
module pics_dp #(
	parameter int FRAC_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire pics_pkg::pics_cmd_t cmd,
	output pics_pkg::pics_stat_t     stat,
	input  wire                      sample_value_we,
	input  wire signed [31:0]        sample_value,
	input  wire signed [31:0]        vertex_x,
	input  wire signed [31:0]        vertex_y,
	input  wire signed [31:0]        vertex_z,
	input  wire signed [31:0]        vertex_param,
	input  wire                      fiber_start,
	input  wire                      set_start,
	output logic signed [31:0]       point_x,
	output logic signed [31:0]       point_y,
	output logic signed [31:0]       point_z,
	output logic signed [31:0]       box_min_x,
	output logic signed [31:0]       box_min_y,
	output logic signed [31:0]       box_min_z,
	output logic signed [31:0]       box_max_x,
	output logic signed [31:0]       box_max_y,
	output logic signed [31:0]       box_max_z
);

	localparam int QW = FRAC_BITS + 1;
	localparam int PW = 32 + QW;

	logic signed [31:0] vin [pics_pkg::NAXES];

	logic signed [31:0] sample_q;
	logic signed [31:0] prev_q [pics_pkg::NAXES];
	logic signed [31:0] prev_param_q;
	logic signed [31:0] cur_q [pics_pkg::NAXES];
	logic signed [31:0] old_q [pics_pkg::NAXES];
	logic signed [31:0] cur_param_q;
	logic signed [31:0] old_param_q;
	logic               first_q;

	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic [QW-1:0]      quo_q;

	logic [31:0]        mag_q [pics_pkg::NAXES];
	logic               neg_q [pics_pkg::NAXES];
	logic [PW-1:0]      prod_q;
	logic               prod_neg_q;
	logic signed [31:0] pt_q [pics_pkg::NAXES];

	logic signed [31:0] lo_q [pics_pkg::NAXES];
	logic signed [31:0] hi_q [pics_pkg::NAXES];
	logic               empty_q;
	logic signed [31:0] res_q [pics_pkg::NAXES];

	logic signed [32:0] d_w;
	logic signed [32:0] e_w;
	logic signed [32:0] ad_w;
	logic signed [32:0] ae_w;
	logic               in_range_w;
	logic [32:0]        trial_w;
	logic               ge_w;
	logic [31:0]        off_w;
	logic signed [31:0] new_lo_w [pics_pkg::NAXES];
	logic signed [31:0] new_hi_w [pics_pkg::NAXES];

	assign vin[0] = vertex_x;
	assign vin[1] = vertex_y;
	assign vin[2] = vertex_z;

	// segment classification from the captured parameters
	always_comb begin
		d_w  = {cur_param_q[31], cur_param_q} - {old_param_q[31], old_param_q};
		e_w  = {sample_q[31], sample_q} - {old_param_q[31], old_param_q};
		ad_w = d_w[32] ? -d_w : d_w;
		ae_w = e_w[32] ? -e_w : e_w;
		in_range_w = ((e_w >= 33'sd0) && (e_w <= d_w)) || ((e_w <= 33'sd0) && (e_w >= d_w));
		stat.emit_direct = (first_q || (cur_param_q == old_param_q))
			&& (cur_param_q == sample_q);
		stat.emit_interp = !first_q && (cur_param_q != old_param_q) && in_range_w;
	end

	// restoring divider step, remainder below the divisor after every step
	always_comb begin
		trial_w = cmd.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge_w    = trial_w >= {1'b0, den_q};
	end

	// interpolation offset of the selected axis
	assign off_w = prod_q[FRAC_BITS +: 32];

	// box widened by the sampled point
	always_comb begin
		for (int k = 0; k < pics_pkg::NAXES; k++) begin
			if (empty_q) begin
				new_lo_w[k] = pt_q[k];
				new_hi_w[k] = pt_q[k];
			end else begin
				new_lo_w[k] = (pt_q[k] < lo_q[k]) ? pt_q[k] : lo_q[k];
				new_hi_w[k] = (pt_q[k] > hi_q[k]) ? pt_q[k] : hi_q[k];
			end
		end
	end

	// architectural state: register, previous vertex, box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q     <= '0;
			prev_param_q <= '0;
			empty_q      <= 1'b1;
			for (int k = 0; k < pics_pkg::NAXES; k++) begin
				prev_q[k] <= '0;
				lo_q[k]   <= '0;
				hi_q[k]   <= '0;
			end
		end else begin
			if (sample_value_we) begin
				sample_q <= sample_value;
			end
			if (cmd.load) begin
				prev_param_q <= vertex_param;
				for (int k = 0; k < pics_pkg::NAXES; k++) begin
					prev_q[k] <= vin[k];
				end
				if (set_start) begin
					empty_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				empty_q <= 1'b0;
				for (int k = 0; k < pics_pkg::NAXES; k++) begin
					lo_q[k] <= new_lo_w[k];
					hi_q[k] <= new_hi_w[k];
				end
			end
		end
	end

	// working registers of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_param_q <= vertex_param;
			old_param_q <= prev_param_q;
			first_q     <= fiber_start | set_start;
			for (int k = 0; k < pics_pkg::NAXES; k++) begin
				cur_q[k] <= vin[k];
				old_q[k] <= prev_q[k];
			end
		end
		if (cmd.eval) begin
			rem_q <= ae_w[31:0];
			den_q <= ad_w[31:0];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge_w ? 32'(trial_w - {1'b0, den_q}) : trial_w[31:0];
			quo_q <= {quo_q[QW-2:0], ge_w};
		end
		if (cmd.diff) begin
			for (int k = 0; k < pics_pkg::NAXES; k++) begin
				logic signed [32:0] dd;
				logic signed [32:0] ad;
				dd = {cur_q[k][31], cur_q[k]} - {old_q[k][31], old_q[k]};
				ad = dd[32] ? -dd : dd;
				mag_q[k] <= ad[31:0];
				neg_q[k] <= dd[32];
			end
		end
		if (cmd.mul) begin
			prod_q     <= {{QW{1'b0}}, mag_q[cmd.axis]} * {{32{1'b0}}, quo_q};
			prod_neg_q <= neg_q[cmd.axis];
		end
		if (cmd.add) begin
			pt_q[cmd.axis] <= prod_neg_q ? old_q[cmd.axis] - $signed(off_w)
				: old_q[cmd.axis] + $signed(off_w);
		end
		if (cmd.pick_cur) begin
			for (int k = 0; k < pics_pkg::NAXES; k++) begin
				pt_q[k] <= cur_q[k];
			end
		end
		if (cmd.commit) begin
			for (int k = 0; k < pics_pkg::NAXES; k++) begin
				res_q[k] <= pt_q[k];
			end
		end
	end

	assign point_x   = res_q[0];
	assign point_y   = res_q[1];
	assign point_z   = res_q[2];
	assign box_min_x = lo_q[0];
	assign box_min_y = lo_q[1];
	assign box_min_z = lo_q[2];
	assign box_max_x = hi_q[0];
	assign box_max_y = hi_q[1];
	assign box_max_z = hi_q[2];

endmodule
`default_nettype wire

### sv/pics_ctrl.sv
// controller: item handshake, divider step count, axis sequencing and result valid
`default_nettype none
module pics_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire                       out_stall,
	output pics_pkg::pics_cmd_t       cmd,
	input  wire pics_pkg::pics_stat_t stat
);

	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [CW-1:0] DIV_LAST = CW'(FRAC_BITS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_DIFF   = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_ADD    = 3'd5;
	localparam logic [2:0] ST_COMMIT = 3'd6;

	logic [2:0]            state_q;
	logic [2:0]            state_d;
	logic [CW-1:0]         cnt_q;
	pics_pkg::axis_t       axis_q;
	logic                  out_valid_q;
	logic                  commit_ok;

	assign commit_ok = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.div_first = (cnt_q == '0);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.emit_direct) begin
					cmd.pick_cur = 1'b1;
					state_d      = ST_COMMIT;
				end else if (stat.emit_interp) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = (axis_q == pics_pkg::AXIS_LAST) ? ST_COMMIT : ST_MUL;
			end
			ST_COMMIT: begin
				if (commit_ok) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			axis_q      <= pics_pkg::AXIS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.eval) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.diff) begin
				axis_q <= pics_pkg::AXIS_FIRST;
			end else if (cmd.add) begin
				axis_q <= axis_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
